[rtl/tcm_pkg.sv]
// ----------------------------------------------------------------------------
// tcm_pkg
// Shared types and constants of the triangular crossfade mixer.
// ----------------------------------------------------------------------------
package tcm_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int MAG_W         = 17;  // |position|, 0 .. 32768
  localparam int N_W           = 4;   // inputs_in_use register width
  localparam int WEIGHT_W      = 16;  // Q1.15 weight, 0 .. 32768 unsigned
  localparam int PROD_W        = 33;  // signed (weight * sample)
  localparam int SUM_W         = 37;  // room for up to 16 lanes
  localparam int SAMPLE_FIELDS = 8;
  localparam int ONE_Q15       = 32768;
  localparam int FRAC_BITS     = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // stage load enables driven by the top-level flow control
  typedef struct packed {
    logic en_w;   // lane weight stage
    logic en_p;   // lane product stage
    logic en_s;   // merge sum stage
    logic en_o;   // merge output stage
  } ctrl_t;

endpackage

[rtl/triangular_crossfade_mixer_top.sv]
// ----------------------------------------------------------------------------
// triangular_crossfade_mixer_top
// Pipeline: input reg, weight, product, lane sum, sign/shift/saturate
//   registers, in that order from input beat to output beat.
// Throughput: one beat per cycle; every stage has its own valid and stalls
//   only when the stage after it is full.
// Reset: synchronous active-low rst_n empties the pipe and sets
//   inputs_in_use to 8.
// ----------------------------------------------------------------------------
module triangular_crossfade_mixer_top #(
  parameter int MAX_INPUTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // position, sample_0 .. sample_7 (16 bits each, lowest first)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // mixed
  output logic [15:0]  out_tdata,
  input  logic         cfg_wen,
  input  logic [3:0]   cfg_wdata
);
  import tcm_pkg::*;

  logic [N_W-1:0]   n_cfg_r;
  logic [N_W-1:0]   n_eff;
  logic             v1_r, v2_r, v3_r, v4_r, v5_r;
  logic             rdy1, rdy2, rdy3, rdy4, rdy5;
  logic [MAG_W-1:0] mag1_r;
  logic             neg1_r, neg2_r, neg3_r;
  sample_t          samp1_r [SAMPLE_FIELDS];
  sample_t          lane_samp [MAX_INPUTS];
  logic [WEIGHT_W-1:0] lane_w [MAX_INPUTS];
  prod_t            lane_prod [MAX_INPUTS];
  logic [MAX_INPUTS-1:0] w_nz;
  ctrl_t            ctrl;
  sample_t          mixed;
  sample_t          pos;

  assign rdy5 = !v5_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_tready = rdy1;
  assign ctrl.en_w = rdy2;
  assign ctrl.en_p = rdy3;
  assign ctrl.en_s = rdy4;
  assign ctrl.en_o = rdy5;

  assign n_eff = (n_cfg_r > N_W'(MAX_INPUTS)) ? N_W'(MAX_INPUTS) : n_cfg_r;
  assign pos   = in_tdata[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_cfg_r <= N_W'(8);
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        n_cfg_r <= cfg_wdata;
      end
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      neg1_r <= pos[SAMPLE_W-1];
      mag1_r <= pos[SAMPLE_W-1] ? MAG_W'(-MAG_W'(pos)) : MAG_W'(pos);
      for (int k = 0; k < SAMPLE_FIELDS; k++) begin
        samp1_r[k] <= in_tdata[SAMPLE_W*(k+1) +: SAMPLE_W];
      end
    end
    if (rdy2) neg2_r <= neg1_r;
    if (rdy3) neg3_r <= neg2_r;
  end

  for (genvar g = 0; g < MAX_INPUTS; g++) begin : g_lane
    if (g < SAMPLE_FIELDS) begin : g_src
      assign lane_samp[g] = samp1_r[g];
    end else begin : g_zero
      assign lane_samp[g] = '0;
    end

    tcm_lane #(
      .LANE_IDX (g)
    ) u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .n_i      (n_eff),
      .mag_i    (mag1_r),
      .samp_i   (lane_samp[g]),
      .weight_o (lane_w[g]),
      .prod_o   (lane_prod[g])
    );

    assign w_nz[g] = (lane_w[g] != '0);
  end

  tcm_merge #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_merge (
    .clk     (clk),
    .ctrl    (ctrl),
    .prod_i  (lane_prod),
    .neg_i   (neg3_r),
    .mixed_o (mixed)
  );

  assign out_tvalid = v5_r;
  assign out_tdata  = mixed;

  // neighboring tents overlap pairwise only
  a_two_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $countones(w_nz) <= 2)
    else $error("more than two lanes carry weight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !v1_r && !v4_r)
    else $error("pipe not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && v2_r && v3_r && v4_r && v5_r)
    else $error("input stalled with a free stage");

endmodule

[rtl/tcm_lane.sv]
// ----------------------------------------------------------------------------
// tcm_lane
// One mixer input: triangular weight from |position|, then weight * sample.
// ----------------------------------------------------------------------------
module tcm_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                      clk,
  input  tcm_pkg::ctrl_t            ctrl,
  input  logic [tcm_pkg::N_W-1:0]   n_i,
  input  logic [tcm_pkg::MAG_W-1:0] mag_i,
  input  tcm_pkg::sample_t          samp_i,
  output logic [tcm_pkg::WEIGHT_W-1:0] weight_o,
  output tcm_pkg::prod_t            prod_o
);
  import tcm_pkg::*;

  localparam int SCL_W = MAG_W + N_W;
  localparam logic [SCL_W-1:0] CENTER = SCL_W'((LANE_IDX + 1) * ONE_Q15);
  localparam logic [SCL_W-1:0] ONE    = SCL_W'(ONE_Q15);

  logic [N_W-1:0]            np1;
  logic [SCL_W-1:0]          scaled;
  logic signed [SCL_W:0]     diff;
  logic [SCL_W-1:0]          absd;
  logic [WEIGHT_W-1:0]       weight_nxt;
  logic [WEIGHT_W-1:0]       weight_r;
  sample_t                   samp_r;
  prod_t                     prod_r;

  assign np1    = n_i + N_W'(1);
  assign scaled = SCL_W'(np1) * SCL_W'(mag_i);
  assign diff   = $signed({1'b0, scaled}) - $signed({1'b0, CENTER});
  assign absd   = diff[SCL_W] ? SCL_W'(-diff) : diff[SCL_W-1:0];

  // lanes past n are silent, even where the tent would reach them
  always_comb begin
    if ((n_i > N_W'(LANE_IDX)) && (absd < ONE)) begin
      weight_nxt = WEIGHT_W'(ONE - absd);
    end else begin
      weight_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_w) begin
      weight_r <= weight_nxt;
      samp_r   <= samp_i;
    end
    if (ctrl.en_p) begin
      prod_r <= $signed({1'b0, weight_r}) * samp_r;
    end
  end

  assign weight_o = weight_r;
  assign prod_o   = prod_r;

endmodule

[rtl/tcm_merge.sv]
// ----------------------------------------------------------------------------
// tcm_merge
// Sums the lane products, applies the position sign, shifts and saturates.
// ----------------------------------------------------------------------------
module tcm_merge #(
  parameter int MAX_INPUTS = 8
) (
  input  logic             clk,
  input  tcm_pkg::ctrl_t   ctrl,
  input  tcm_pkg::prod_t   prod_i [MAX_INPUTS],
  input  logic             neg_i,
  output tcm_pkg::sample_t mixed_o
);
  import tcm_pkg::*;

  localparam int SH_W = SUM_W - FRAC_BITS;

  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic                    neg_r;
  logic signed [SUM_W-1:0] acc;
  logic signed [SH_W-1:0]  shifted;
  sample_t                 mixed_nxt;
  sample_t                 mixed_r;

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < MAX_INPUTS; k++) begin
      sum_nxt = sum_nxt + SUM_W'(prod_i[k]);
    end
  end

  assign acc     = neg_r ? -sum_r : sum_r;
  assign shifted = acc[SUM_W-1:FRAC_BITS];   // floor shift

  always_comb begin
    if (shifted > SH_W'(32767)) begin
      mixed_nxt = 16'sh7fff;
    end else if (shifted < -SH_W'(32768)) begin
      mixed_nxt = 16'sh8000;
    end else begin
      mixed_nxt = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_s) begin
      sum_r <= sum_nxt;
      neg_r <= neg_i;
    end
    if (ctrl.en_o) begin
      mixed_r <= mixed_nxt;
    end
  end

  assign mixed_o = mixed_r;

endmodule
